@@ hdl/smfc_pkg.sv @@
// ----------------------------------------------------------------------------
// smfc_pkg
// Shared types and constants of the register-mapped SPI master: request and
// response payloads, bus offsets, transfer phases and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package smfc_pkg;

  // fifo geometry
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = 3;

  // request kinds
  localparam logic [1:0] REQ_BUS_WRITE = 2'd0;
  localparam logic [1:0] REQ_BUS_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK      = 2'd2;

  // register offsets
  localparam logic [3:0] OFF_OPCODE  = 4'h0;
  localparam logic [3:0] OFF_COUNT   = 4'h1;
  localparam logic [3:0] OFF_CONTROL = 4'h2;
  localparam logic [3:0] OFF_FIFO    = 4'hC;
  localparam logic [3:0] OFF_POINTER = 4'hD;

  // control register bits and count limits
  localparam int         CTRL_EXEC_BIT = 0;
  localparam int         CTRL_PRST_BIT = 4;
  localparam logic [7:0] CTRL_STORE_MASK = 8'hEF;
  localparam logic [3:0] COUNT_MAX       = 4'd8;
  localparam logic [2:0] BIT_LAST        = 3'd7;

  // transfer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_WRITE,
    PH_READ
  } phase_t;

  // request payload
  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic       miso_bit;
  } req_t;

  // response payload
  typedef struct packed {
    logic [7:0] read_data;
    logic       busy_res;
    logic       chip_select;
    logic       mosi_bit;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic bus_wr;      // register write while idle
    logic bus_rd;      // register read
    logic bus_rd_adv;  // fifo read advances pointer
    logic start;       // begin a transfer
    logic tick;        // move one serial bit
    logic shift_out;   // tick drives mosi (opcode or write phase)
    logic load_byte;   // load next write byte from fifo
    logic byte_clr;    // clear byte counter
    logic byte_inc;    // advance byte counter
    logic rd_enter;    // enter read phase
    logic rd_store;    // store received byte into fifo
    logic finish;      // clear execute bit
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_bit;
    logic wr_nz;
    logic rd_nz;
    logic wr_more;
    logic rd_done;
    logic exec_bit;
  } dp_stat_t;

endpackage

@@ hdl/smfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// smfc_ctrl
// Transfer sequencer: tracks the phase (opcode, write bytes, read bytes) and
// issues per-request commands to the datapath.
// ----------------------------------------------------------------------------
module smfc_ctrl
  import smfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  req_t     req,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy_now,
  output logic     busy_after
);

  phase_t phase;
  phase_t phase_next;
  logic   is_wr;
  logic   is_rd;
  logic   is_tick;
  logic   byte_end;

  // request decode
  assign is_wr    = accept && (req.req_type == REQ_BUS_WRITE);
  assign is_rd    = accept && (req.req_type == REQ_BUS_READ);
  assign is_tick  = accept && (req.req_type == REQ_TICK) && (phase != PH_IDLE);
  assign byte_end = is_tick && stat.last_bit;

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (is_wr && (req.reg_offset == OFF_CONTROL) && req.write_data[CTRL_EXEC_BIT]) begin
          phase_next = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        if (byte_end) begin
          if (stat.wr_nz) begin
            phase_next = PH_WRITE;
          end else if (stat.rd_nz) begin
            phase_next = PH_READ;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_WRITE: begin
        if (byte_end && !stat.wr_more) begin
          phase_next = stat.rd_nz ? PH_READ : PH_IDLE;
        end
      end
      PH_READ: begin
        if (byte_end && stat.rd_done) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.bus_wr     = is_wr && (phase == PH_IDLE);
    cmd.bus_rd     = is_rd;
    cmd.bus_rd_adv = is_rd && (req.reg_offset == OFF_FIFO) && (phase == PH_IDLE);
    cmd.start      = cmd.bus_wr && (req.reg_offset == OFF_CONTROL)
                     && req.write_data[CTRL_EXEC_BIT];
    cmd.tick       = is_tick;
    cmd.shift_out  = (phase == PH_OPCODE) || (phase == PH_WRITE);
    case (phase)
      PH_OPCODE: begin
        if (byte_end) begin
          if (stat.wr_nz) begin
            cmd.load_byte = 1'b1;
            cmd.byte_clr  = 1'b1;
          end else if (stat.rd_nz) begin
            cmd.rd_enter = 1'b1;
          end else begin
            cmd.finish = 1'b1;
          end
        end
      end
      PH_WRITE: begin
        if (byte_end) begin
          cmd.byte_inc = 1'b1;
          if (stat.wr_more) begin
            cmd.load_byte = 1'b1;
          end else if (stat.rd_nz) begin
            cmd.rd_enter = 1'b1;
          end else begin
            cmd.finish = 1'b1;
          end
        end
      end
      PH_READ: begin
        if (byte_end) begin
          cmd.rd_store = 1'b1;
          cmd.byte_inc = 1'b1;
          cmd.finish   = stat.rd_done;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_now   = (phase != PH_IDLE);
  assign busy_after = (phase_next != PH_IDLE);

endmodule

@@ hdl/smfc_dp.sv @@
// ----------------------------------------------------------------------------
// smfc_dp
// Register file, byte fifo with auto-incrementing pointer, serial shifter and
// bit/byte counters of the SPI master.
// ----------------------------------------------------------------------------
module smfc_dp
  import smfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  output logic [7:0] read_data,
  output logic       mosi_bit
);

  logic [7:0]       opcode_reg;
  logic [7:0]       count_reg;
  logic [7:0]       control_reg;
  logic [7:0]       fifo_store [FIFO_DEPTH];
  logic [PTR_W-1:0] fifo_pointer;
  logic [7:0]       shift_byte;
  logic [2:0]       bit_counter;
  logic [4:0]       byte_counter;

  logic [7:0]       fifo_word;
  logic [7:0]       shifted;
  logic [5:0]       byte_plus;
  logic [3:0]       cnt_lo;
  logic [3:0]       cnt_hi;
  logic             wr_fifo;

  assign fifo_word = fifo_store[fifo_pointer];
  assign shifted   = cmd.shift_out ? {shift_byte[6:0], 1'b0}
                                   : {shift_byte[6:0], req.miso_bit};
  assign byte_plus = {1'b0, byte_counter} + 6'd1;

  // count clamp
  assign cnt_lo = (req.write_data[3:0] > COUNT_MAX) ? COUNT_MAX : req.write_data[3:0];
  assign cnt_hi = (req.write_data[7:4] > COUNT_MAX) ? COUNT_MAX : req.write_data[7:4];

  assign wr_fifo = cmd.bus_wr && (req.reg_offset == OFF_FIFO);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      opcode_reg  <= '0;
      count_reg   <= '0;
      control_reg <= '0;
    end else begin
      if (cmd.bus_wr && (req.reg_offset == OFF_OPCODE)) begin
        opcode_reg <= req.write_data;
      end
      if (cmd.bus_wr && (req.reg_offset == OFF_COUNT)) begin
        count_reg <= {cnt_hi, cnt_lo};
      end
      if (cmd.bus_wr && (req.reg_offset == OFF_CONTROL)) begin
        control_reg <= req.write_data & CTRL_STORE_MASK;
      end else if (cmd.finish) begin
        control_reg[CTRL_EXEC_BIT] <= 1'b0;
      end
    end
  end

  // fifo pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_pointer <= '0;
    end else if (cmd.bus_wr && (req.reg_offset == OFF_CONTROL)
                 && req.write_data[CTRL_PRST_BIT]) begin
      fifo_pointer <= '0;
    end else if (wr_fifo || cmd.bus_rd_adv || cmd.load_byte || cmd.rd_store) begin
      fifo_pointer <= fifo_pointer + 1'b1;
    end
  end

  // fifo storage
  always_ff @(posedge clk) begin
    if (wr_fifo) begin
      fifo_store[fifo_pointer] <= req.write_data;
    end else if (cmd.rd_store) begin
      fifo_store[fifo_pointer] <= shifted;
    end
  end

  // shifter and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte   <= '0;
      bit_counter  <= '0;
      byte_counter <= '0;
    end else begin
      if (cmd.start) begin
        shift_byte <= opcode_reg;
      end else if (cmd.load_byte) begin
        shift_byte <= fifo_word;
      end else if (cmd.rd_enter || cmd.rd_store) begin
        shift_byte <= '0;
      end else if (cmd.tick) begin
        shift_byte <= shifted;
      end

      if (cmd.start) begin
        bit_counter <= '0;
      end else if (cmd.tick) begin
        bit_counter <= bit_counter + 1'b1;
      end

      if (cmd.start || cmd.byte_clr || cmd.rd_enter) begin
        byte_counter <= '0;
      end else if (cmd.byte_inc) begin
        byte_counter <= byte_plus[4:0];
      end
    end
  end

  // status to controller
  assign stat.last_bit = (bit_counter == BIT_LAST);
  assign stat.wr_nz    = (count_reg[3:0] != 4'd0);
  assign stat.rd_nz    = (count_reg[7:4] != 4'd0);
  assign stat.wr_more  = (byte_plus < {2'b00, count_reg[3:0]});
  assign stat.rd_done  = (byte_plus >= {2'b00, count_reg[7:4]});
  assign stat.exec_bit = control_reg[CTRL_EXEC_BIT];

  // bus read mux
  always_comb begin
    read_data = '0;
    if (cmd.bus_rd) begin
      case (req.reg_offset)
        OFF_OPCODE:  read_data = opcode_reg;
        OFF_COUNT:   read_data = count_reg;
        OFF_CONTROL: read_data = control_reg;
        OFF_FIFO:    read_data = fifo_word;
        OFF_POINTER: read_data = {{(8-PTR_W){1'b0}}, fifo_pointer};
        default:     read_data = '0;
      endcase
    end
  end

  assign mosi_bit = cmd.tick && cmd.shift_out && shift_byte[7];

endmodule

@@ hdl/spi_master_fifo_controller_core.sv @@
// An accepted request's response is held in the output register from the next cycle.
// Throughput: one request per cycle; each request is a single register update
// of the phase sequencer and datapath, and the output register frees as it is taken.
// A request is held off only while a response waits unread.
// Reset (rst, synchronous): registers, pointer, counters cleared, phase idle, no response.
// ----------------------------------------------------------------------------
// spi_master_fifo_controller_core
// Register-mapped SPI master with an 8-byte fifo: bus reads and writes of the
// register file and serial bit ticks, one response per request.
// ----------------------------------------------------------------------------
module spi_master_fifo_controller_core
  import smfc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_item,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_item
);

  logic       accept;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       busy_now;
  logic       busy_after;
  logic [7:0] rd_byte;
  logic       mosi;
  rsp_t       rsp_next;

  // request handshake
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  smfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req        (req_item),
    .stat       (stat),
    .cmd        (cmd),
    .busy_now   (busy_now),
    .busy_after (busy_after)
  );

  smfc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req_item),
    .cmd       (cmd),
    .stat      (stat),
    .read_data (rd_byte),
    .mosi_bit  (mosi)
  );

  // response assembly
  always_comb begin
    rsp_next.read_data   = rd_byte;
    rsp_next.busy_res    = busy_after;
    rsp_next.chip_select = cmd.tick || busy_after;
    rsp_next.mosi_bit    = mosi;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_item <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // execute bit tracks the sequencer phase
  a_exec_matches_phase: assert property (@(posedge clk) disable iff (rst)
    busy_now == stat.exec_bit)
    else $error("execute bit and transfer phase disagree");

  // a driven serial bit always comes with chip select
  a_mosi_under_cs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.mosi_bit |-> rsp_item.chip_select)
    else $error("mosi driven without chip select");

  // busy always keeps chip select asserted
  a_busy_under_cs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.busy_res |-> rsp_item.chip_select)
    else $error("busy response without chip select");
`endif

endmodule
